>>> rtl/range_list_text_parser_unit_defines.svh
// Assertion macros for the range list text parser unit.
// Included by the modules that check their own logic; empty when SYNTH is set.
`ifndef RANGE_LIST_TEXT_PARSER_UNIT_DEFINES_SVH
`define RANGE_LIST_TEXT_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on the rising clock edge outside reset
`define RLTP_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication, sampled on the rising clock edge outside reset
`define RLTP_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define RLTP_ASSERT_IMPL(name, pre, post, msg)
`define RLTP_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

>>> rtl/rltp_pkg.sv
// Shared types and constants of the range list text parser unit.
// No dependencies; imported by the scanner, the resolver and the top level.
package rltp_pkg;

  // Default width of bounds and resolved values
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Characters of the range list syntax
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LOWER_BOUND = 1'b0,
    REG_UPPER_BOUND = 1'b1
  } cfg_reg_e;

  // Base a bound offset is taken against
  typedef enum logic [1:0] {
    KIND_ABS   = 2'd0,
    KIND_LOWER = 2'd1,
    KIND_UPPER = 2'd2
  } kind_e;

  // Control part of one closed entry, passed from scanner to resolver
  typedef struct packed {
    logic  fail;
    logic  inv;
    logic  fin;
    kind_e f_kind;
    logic  f_neg;
    kind_e t_kind;
    logic  t_neg;
  } rltp_sum_t;

endpackage

>>> rtl/range_list_text_parser_unit.sv
// Range list text parser: one character beat in, one result beat per entry.
// A closing beat, once accepted, lands in the input register, then the scanner
// summary register, then the result register, which presents the result.
// Throughput: one character per cycle; the whole pipeline stalls only while a
// result waits on m_axis_tready. Reset clears the parse state and all valid
// flags, and sets lower_bound to 0 and upper_bound to the largest value.
`include "range_list_text_parser_unit_defines.svh"

module range_list_text_parser_unit #(
  parameter int unsigned VALUE_BITS = rltp_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [rltp_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [VALUE_BITS-1:0]                 cfg_data_i,
  // character stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [7:0]                            s_axis_tdata,  // text_char
  input  logic                                  s_axis_tlast,  // final_char
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // from_value, to_value, zero fill
  output logic [((2*VALUE_BITS+7)/8)*8-1:0]     m_axis_tdata,
  output logic [1:0]                            m_axis_tuser,  // failed, inverted
  output logic                                  m_axis_tlast   // string_done
);
  import rltp_pkg::*;

  localparam int unsigned OUT_W = ((2*VALUE_BITS+7)/8)*8;

  logic                          adv;
  logic                          in_valid_q;
  logic [7:0]                    in_char_q;
  logic                          in_last_q;
  logic signed [VALUE_BITS-1:0]  lower_q, upper_q;

  logic                          sum_valid;
  rltp_sum_t                     sum;
  logic [VALUE_BITS-1:0]         f_mag, t_mag;

  logic                          out_valid, failed, inverted, done;
  logic signed [VALUE_BITS-1:0]  from_value, to_value;

  // Advance the pipeline unless a result is held back
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Bound registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= '0;
      upper_q <= {1'b0, {(VALUE_BITS-1){1'b1}}};
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_LOWER_BOUND: lower_q <= cfg_data_i;
        REG_UPPER_BOUND: upper_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rltp_scan #(
    .VALUE_BITS (VALUE_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (in_valid_q),
    .char_i      (in_char_q),
    .last_i      (in_last_q),
    .sum_valid_o (sum_valid),
    .sum_o       (sum),
    .f_mag_o     (f_mag),
    .t_mag_o     (t_mag)
  );

  rltp_resolve #(
    .VALUE_BITS (VALUE_BITS)
  ) u_resolve (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .sum_valid_i (sum_valid),
    .sum_i       (sum),
    .f_mag_i     (f_mag),
    .t_mag_i     (t_mag),
    .lower_i     (lower_q),
    .upper_i     (upper_q),
    .out_valid_o (out_valid),
    .failed_o    (failed),
    .inverted_o  (inverted),
    .from_o      (from_value),
    .to_o        (to_value),
    .done_o      (done)
  );

  // Pack the result beat
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'({to_value, from_value});
  assign m_axis_tuser  = {inverted, failed};
  assign m_axis_tlast  = done;

  `RLTP_ASSERT_NEXT(a_in_hold, in_valid_q && !adv, in_valid_q && $stable(in_char_q) && $stable(in_last_q), "input register lost a stalled character")

endmodule

>>> rtl/rltp_scan.sv
// Character scanner of the range list text parser: entry state machine,
// decimal accumulator and the registered summary of each closed entry.
// Depends on rltp_pkg and range_list_text_parser_unit_defines.svh.
`include "range_list_text_parser_unit_defines.svh"

module rltp_scan #(
  parameter int unsigned VALUE_BITS = rltp_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    in_valid_i,
  input  logic [7:0]              char_i,
  input  logic                    last_i,
  output logic                    sum_valid_o,
  output rltp_pkg::rltp_sum_t     sum_o,
  output logic [VALUE_BITS-1:0]   f_mag_o,
  output logic [VALUE_BITS-1:0]   t_mag_o
);
  import rltp_pkg::*;

  localparam int unsigned PW = VALUE_BITS + 4;
  localparam logic [VALUE_BITS-1:0] VTOP = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] VSAT = VTOP | VALUE_BITS'(1);

  typedef enum logic [2:0] {
    PH_START,
    PH_FPRE,
    PH_FNUM,
    PH_TPRE,
    PH_TNUM,
    PH_SKIP
  } phase_e;

  phase_e                  phase_q, phase_d, ph;
  logic                    inv_q, inv_d;
  kind_e                   skind_q, skind_d;
  logic [VALUE_BITS-1:0]   smag_q, smag_d;
  logic                    sneg_q, sneg_d;
  logic                    sseen_q, sseen_d;
  kind_e                   ekind_q, ekind_d;
  logic [VALUE_BITS-1:0]   acc_q, acc_d;
  logic                    neg_q, neg_d;
  logic                    dig_q, dig_d;
  logic                    fail_q, fail_d;

  logic                    sum_valid_q;
  rltp_sum_t               sum_q;
  logic [VALUE_BITS-1:0]   f_mag_q, t_mag_q;

  logic                    step;
  logic                    emit;
  rltp_sum_t               e_sum;
  logic [VALUE_BITS-1:0]   e_fmag, e_tmag;

  logic                    is_digit, is_sign, is_prefix, is_num;
  logic [3:0]              digit_val;
  logic [PW-1:0]           prod;
  logic                    ovf;
  logic [VALUE_BITS-1:0]   num_acc;
  logic                    num_neg;
  logic                    num_ovf;

  // close-from on a separator, taken from the stored number
  logic [VALUE_BITS-1:0]   cf_mag;
  logic                    cf_neg, cf_fail, cf_seen;
  kind_e                   cf_kind;
  // close-to on a separator
  logic [VALUE_BITS-1:0]   ct_mag;
  logic                    ct_neg, ct_fail;
  kind_e                   ct_kind;

  assign step = adv_i && in_valid_i;

  // Character classes
  assign is_digit  = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign is_sign   = (char_i == CH_MINUS) || (char_i == CH_PLUS);
  assign is_prefix = (char_i == CH_DOLLAR) || (char_i == CH_TILDE);
  assign is_num    = is_digit || (!dig_q && is_sign);
  assign digit_val = 4'(char_i - CH_ZERO);

  // Multiply by ten and add the digit; saturate above the top magnitude
  assign prod    = PW'({acc_q, 3'b000}) + PW'({acc_q, 1'b0}) + PW'(digit_val);
  assign ovf     = prod > PW'(VTOP);
  assign num_acc = is_digit ? (ovf ? VSAT : prod[VALUE_BITS-1:0]) : acc_q;
  assign num_neg = is_digit ? neg_q : (char_i == CH_MINUS);
  assign num_ovf = is_digit && ovf;

  // Close the from bound: an empty bound with no prefix means lower bound plus zero
  assign cf_mag  = dig_q ? acc_q : '0;
  assign cf_neg  = dig_q && (neg_q ^ (skind_q == KIND_UPPER));
  assign cf_fail = dig_q && !neg_q && acc_q[VALUE_BITS-1];
  assign cf_seen = dig_q || (skind_q != KIND_ABS);
  assign cf_kind = (!dig_q && (skind_q == KIND_ABS)) ? KIND_LOWER : skind_q;

  // Close the to bound: empty bound means upper bound when a from bound exists
  assign ct_mag  = dig_q ? acc_q : '0;
  assign ct_neg  = dig_q && (neg_q ^ (ekind_q == KIND_UPPER));
  assign ct_fail = dig_q ? (!neg_q && acc_q[VALUE_BITS-1])
                         : ((ekind_q == KIND_ABS) && !sseen_q);
  assign ct_kind = (!dig_q && (ekind_q == KIND_ABS)) ? KIND_UPPER : ekind_q;

  // Next entry state and the summary of an entry closed by this beat
  always_comb begin
    ph = phase_q;
    if (ph == PH_START && char_i != CH_CARET) ph = PH_FPRE;
    if (ph == PH_FPRE && !is_prefix) ph = PH_FNUM;
    if (ph == PH_TPRE && !is_prefix) ph = PH_TNUM;

    phase_d = ph;
    inv_d   = inv_q;
    skind_d = skind_q;
    smag_d  = smag_q;
    sneg_d  = sneg_q;
    sseen_d = sseen_q;
    ekind_d = ekind_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    dig_d   = dig_q;
    fail_d  = fail_q;

    emit          = 1'b0;
    e_sum.fail    = 1'b1;
    e_sum.inv     = inv_q || (phase_q == PH_START && char_i == CH_CARET);
    e_sum.fin     = last_i;
    e_sum.f_kind  = skind_q;
    e_sum.f_neg   = sneg_q;
    e_sum.t_kind  = KIND_ABS;
    e_sum.t_neg   = 1'b0;
    e_fmag        = smag_q;
    e_tmag        = '0;

    case (ph)
      PH_START: begin
        inv_d   = 1'b1;
        phase_d = PH_FPRE;
        emit    = last_i;
      end
      PH_FPRE: begin
        skind_d = (char_i == CH_DOLLAR) ? KIND_UPPER : KIND_LOWER;
        phase_d = PH_FNUM;
        if (last_i) begin
          emit         = 1'b1;
          e_sum.fail   = fail_q;
          e_sum.f_kind = skind_d;
          e_sum.f_neg  = 1'b0;
          e_sum.t_kind = skind_d;
          e_fmag       = '0;
        end
      end
      PH_FNUM: begin
        if (is_num) begin
          acc_d  = num_acc;
          neg_d  = num_neg;
          dig_d  = 1'b1;
          fail_d = fail_q || num_ovf;
          if (last_i) begin
            emit         = 1'b1;
            e_sum.fail   = fail_q || num_ovf || (!num_neg && num_acc[VALUE_BITS-1]);
            e_sum.f_kind = skind_q;
            e_sum.f_neg  = num_neg ^ (skind_q == KIND_UPPER);
            e_sum.t_kind = skind_q;
            e_sum.t_neg  = e_sum.f_neg;
            e_fmag       = num_acc;
            e_tmag       = num_acc;
          end
        end else begin
          skind_d = cf_kind;
          smag_d  = cf_mag;
          sneg_d  = cf_neg;
          sseen_d = cf_seen;
          fail_d  = fail_q || cf_fail;
          acc_d   = '0;
          neg_d   = 1'b0;
          dig_d   = 1'b0;
          e_sum.f_kind = cf_kind;
          e_sum.f_neg  = cf_neg;
          e_fmag       = cf_mag;
          if (char_i == CH_COMMA) begin
            emit         = 1'b1;
            e_sum.fail   = fail_q || cf_fail || !cf_seen;
            e_sum.t_kind = cf_kind;
            e_sum.t_neg  = cf_neg;
            e_tmag       = cf_mag;
          end else if (char_i == CH_COLON) begin
            phase_d = PH_TPRE;
            if (last_i) begin
              emit         = 1'b1;
              e_sum.fail   = fail_q || cf_fail || !cf_seen;
              e_sum.t_kind = KIND_UPPER;
            end
          end else begin
            fail_d  = 1'b1;
            phase_d = PH_SKIP;
            emit    = last_i;
          end
        end
      end
      PH_TPRE: begin
        ekind_d = (char_i == CH_DOLLAR) ? KIND_UPPER : KIND_LOWER;
        phase_d = PH_TNUM;
        if (last_i) begin
          emit         = 1'b1;
          e_sum.fail   = fail_q;
          e_sum.t_kind = ekind_d;
        end
      end
      PH_TNUM: begin
        if (is_num) begin
          acc_d  = num_acc;
          neg_d  = num_neg;
          dig_d  = 1'b1;
          fail_d = fail_q || num_ovf;
          if (last_i) begin
            emit         = 1'b1;
            e_sum.fail   = fail_q || num_ovf || (!num_neg && num_acc[VALUE_BITS-1]);
            e_sum.t_kind = ekind_q;
            e_sum.t_neg  = num_neg ^ (ekind_q == KIND_UPPER);
            e_tmag       = num_acc;
          end
        end else if (char_i == CH_COMMA) begin
          emit         = 1'b1;
          e_sum.fail   = fail_q || ct_fail;
          e_sum.t_kind = ct_kind;
          e_sum.t_neg  = ct_neg;
          e_tmag       = ct_mag;
        end else begin
          fail_d  = 1'b1;
          phase_d = PH_SKIP;
          emit    = last_i;
        end
      end
      default: begin
        // drop characters up to the next separator
        fail_d  = 1'b1;
        phase_d = PH_SKIP;
        emit    = (char_i == CH_COMMA) || last_i;
      end
    endcase

    // Start a fresh entry after every result
    if (emit) begin
      phase_d = PH_START;
      inv_d   = 1'b0;
      skind_d = KIND_ABS;
      smag_d  = '0;
      sneg_d  = 1'b0;
      sseen_d = 1'b0;
      ekind_d = KIND_ABS;
      acc_d   = '0;
      neg_d   = 1'b0;
      dig_d   = 1'b0;
      fail_d  = 1'b0;
    end
  end

  // Hold entry state and the summary register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      inv_q       <= 1'b0;
      skind_q     <= KIND_ABS;
      smag_q      <= '0;
      sneg_q      <= 1'b0;
      sseen_q     <= 1'b0;
      ekind_q     <= KIND_ABS;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      dig_q       <= 1'b0;
      fail_q      <= 1'b0;
      sum_valid_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q <= phase_d;
        inv_q   <= inv_d;
        skind_q <= skind_d;
        smag_q  <= smag_d;
        sneg_q  <= sneg_d;
        sseen_q <= sseen_d;
        ekind_q <= ekind_d;
        acc_q   <= acc_d;
        neg_q   <= neg_d;
        dig_q   <= dig_d;
        fail_q  <= fail_d;
      end
      if (adv_i) begin
        sum_valid_q <= step && emit;
      end
    end
  end

  // Summary payload; no reset needed
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sum_q   <= e_sum;
      f_mag_q <= e_fmag;
      t_mag_q <= e_tmag;
    end
  end

  assign sum_valid_o = sum_valid_q;
  assign sum_o       = sum_q;
  assign f_mag_o     = f_mag_q;
  assign t_mag_o     = t_mag_q;

  `RLTP_ASSERT_IMPL(a_sat_sets_fail, acc_q > VTOP, fail_q, "saturated accumulator without fail")
  `RLTP_ASSERT_IMPL(a_acc_range, 1'b1, acc_q <= VSAT, "accumulator beyond saturation value")
  `RLTP_ASSERT_NEXT(a_clear_after_emit, step && emit, phase_q == PH_START && !fail_q && !dig_q && !inv_q, "entry state not cleared after result")

endmodule

>>> rtl/rltp_resolve.sv
// Bound resolver of the range list text parser: turns an entry summary into
// absolute from/to values, checks them against the bounds, holds the result.
// Depends on rltp_pkg and range_list_text_parser_unit_defines.svh.
`include "range_list_text_parser_unit_defines.svh"

module rltp_resolve #(
  parameter int unsigned VALUE_BITS = rltp_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          sum_valid_i,
  input  rltp_pkg::rltp_sum_t           sum_i,
  input  logic [VALUE_BITS-1:0]         f_mag_i,
  input  logic [VALUE_BITS-1:0]         t_mag_i,
  input  logic signed [VALUE_BITS-1:0]  lower_i,
  input  logic signed [VALUE_BITS-1:0]  upper_i,
  output logic                          out_valid_o,
  output logic                          failed_o,
  output logic                          inverted_o,
  output logic signed [VALUE_BITS-1:0]  from_o,
  output logic signed [VALUE_BITS-1:0]  to_o,
  output logic                          done_o
);
  import rltp_pkg::*;

  localparam int unsigned SW = VALUE_BITS + 2;

  logic                          out_valid_q;
  logic                          failed_q, inv_q, done_q;
  logic signed [VALUE_BITS-1:0]  from_q, to_q;

  logic signed [SW-1:0]          lo_x, hi_x, f_val, t_val;
  logic                          bad;

  // Base plus or minus the offset magnitude
  function automatic logic signed [SW-1:0] resolve_val(
    input kind_e                 kind,
    input logic [VALUE_BITS-1:0] mag,
    input logic                  neg,
    input logic signed [SW-1:0]  lo,
    input logic signed [SW-1:0]  hi
  );
    logic signed [SW-1:0] base;
    logic signed [SW-1:0] mag_x;
    base  = (kind == KIND_LOWER) ? lo : ((kind == KIND_UPPER) ? hi : '0);
    mag_x = signed'({2'b00, mag});
    return neg ? (base - mag_x) : (base + mag_x);
  endfunction

  assign lo_x  = SW'(lower_i);
  assign hi_x  = SW'(upper_i);
  assign f_val = resolve_val(sum_i.f_kind, f_mag_i, sum_i.f_neg, lo_x, hi_x);
  assign t_val = resolve_val(sum_i.t_kind, t_mag_i, sum_i.t_neg, lo_x, hi_x);

  // Fail on parse errors or on either end outside the bounds
  assign bad = sum_i.fail || (f_val < lo_x) || (f_val > hi_x)
                          || (t_val < lo_x) || (t_val > hi_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= sum_valid_i;
    end
  end

  // Result payload; zero values on failure
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      failed_q <= bad;
      inv_q    <= sum_i.inv;
      done_q   <= sum_i.fin;
      from_q   <= bad ? '0 : f_val[VALUE_BITS-1:0];
      to_q     <= bad ? '0 : t_val[VALUE_BITS-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign failed_o    = failed_q;
  assign inverted_o  = inv_q;
  assign from_o      = from_q;
  assign to_o        = to_q;
  assign done_o      = done_q;

  `RLTP_ASSERT_IMPL(a_fail_zero, out_valid_q && failed_q, from_q == '0 && to_q == '0, "failed result with non-zero values")

endmodule

>>> bench/tb_range_list_text_parser_unit.sv
// Self-checking bench for range_list_text_parser_unit: directed entries, then random
// range-list text under several bound settings, checked against an in-bench predictor.
// Depends on rltp_pkg and the unit's RTL only.
module tb_range_list_text_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rltp_pkg::*;

  localparam int     VW         = VALUE_BITS_DEF;
  localparam longint VTOP       = longint'(1) << (VW - 1);
  localparam int     IDLE_LIMIT = 2000;
  localparam int     HOLD_LEN   = 120;
  localparam int     N_PROBES   = 25;
  localparam int     N_PHASES   = 6;

  // One parsed entry as seen on the result stream
  typedef struct packed {
    logic          failed;
    logic          inverted;
    logic [VW-1:0] from_v;
    logic [VW-1:0] to_v;
    logic          done;
  } range_res_t;

  // Directed entry: its text, whether its last character closes the string,
  // and a hand-written result where one is obvious
  typedef struct {
    string text;
    bit    fin;
    bit    typed;
    bit    failed;
    bit    inverted;
    int    from_v;
    int    to_v;
  } probe_t;

  typedef enum int {
    SCAN_ENTRY, SCAN_FPRE, SCAN_FNUM, SCAN_TPRE, SCAN_TNUM, SCAN_SKIP
  } scan_phase_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we        = 1'b0;
  cfg_reg_e              cfg_index     = REG_LOWER_BOUND;
  logic [VW-1:0]         cfg_data      = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [2*VW-1:0]       m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  range_list_text_parser_unit #(
    .VALUE_BITS(VW)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // text_char
    .s_axis_tlast (s_axis_tlast),   // final_char
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // from_value, to_value
    .m_axis_tuser (m_axis_tuser),   // failed, inverted
    .m_axis_tlast (m_axis_tlast)    // string_done
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Bound registers as the bench last wrote them
  logic [VW-1:0] lower_q = '0;
  logic [VW-1:0] upper_q = VW'(VTOP - 1);

  // Parse state of the predictor
  scan_phase_e scan_phase  = SCAN_ENTRY;
  bit          caret_seen  = 1'b0;
  kind_e       from_kind   = KIND_ABS;
  longint      from_off    = 0;
  bit          from_given  = 1'b0;
  kind_e       to_kind     = KIND_ABS;
  longint      num_mag     = 0;
  bit          num_neg     = 1'b0;
  bit          num_any     = 1'b0;
  bit          entry_bad   = 1'b0;

  range_res_t  expected_ranges [$];
  range_res_t  oldest_range;
  logic [7:0]  line_buf [$];
  int          mismatches    = 0;
  int          idle_cycles   = 0;
  bit          sender_quiet  = 1'b0;
  bit          sink_quiet    = 1'b0;
  bit          calm          = 1'b0;
  bit          hold_req      = 1'b0;
  bit          hold_taken    = 1'b0;
  int          hold_left     = 0;
  int          stall_left    = 0;

  function automatic void wipe_entry();
    scan_phase = SCAN_ENTRY;
    caret_seen = 1'b0;
    from_kind  = KIND_ABS;
    from_off   = 0;
    from_given = 1'b0;
    to_kind    = KIND_ABS;
    num_mag    = 0;
    num_neg    = 1'b0;
    num_any    = 1'b0;
    entry_bad  = 1'b0;
  endfunction

  // Accumulate one decimal digit, saturating just past the signed range
  function automatic void push_digit(int d);
    if (num_mag > (VTOP - d) / 10) begin
      entry_bad = 1'b1;
      num_mag   = VTOP + 1;
    end else begin
      num_mag = num_mag * 10 + d;
    end
  endfunction

  // Signed value of the collected number; an upper-based offset counts back
  function automatic longint take_value(kind_e k);
    longint m;
    longint v;
    m = num_mag;
    if (num_neg) begin
      if (m > VTOP) begin
        entry_bad = 1'b1;
        m = 0;
      end
      v = -m;
    end else begin
      if (m > VTOP - 1) begin
        entry_bad = 1'b1;
        m = 0;
      end
      v = m;
    end
    num_mag = 0;
    num_neg = 1'b0;
    num_any = 1'b0;
    return (k == KIND_UPPER) ? -v : v;
  endfunction

  function automatic void close_from();
    if (num_any) begin
      from_off   = take_value(from_kind);
      from_given = 1'b1;
    end else begin
      from_off = 0;
      // an empty start with no prefix means the lower bound
      if (from_kind != KIND_ABS) from_given = 1'b1;
      else from_kind = KIND_LOWER;
    end
  endfunction

  function automatic longint close_to();
    if (num_any) return take_value(to_kind);
    // an empty end means the upper bound, unless no start was written either
    if (to_kind == KIND_ABS) begin
      if (!from_given) entry_bad = 1'b1;
      else to_kind = KIND_UPPER;
    end
    return 0;
  endfunction

  function automatic longint value_at(kind_e k, longint off);
    if (k == KIND_LOWER) return longint'($signed(lower_q)) + off;
    if (k == KIND_UPPER) return longint'($signed(upper_q)) + off;
    return off;
  endfunction

  // Resolve both ends, check them against the bounds and clear the entry
  function automatic range_res_t finish_entry(kind_e tk, longint toff, bit fin);
    longint     lo;
    longint     hi;
    longint     f;
    longint     t;
    bit         bad;
    range_res_t r;
    lo  = longint'($signed(lower_q));
    hi  = longint'($signed(upper_q));
    f   = value_at(from_kind, from_off);
    t   = value_at(tk, toff);
    bad = entry_bad;
    if (f < lo || f > hi || t < lo || t > hi) bad = 1'b1;
    if (bad) begin
      f = 0;
      t = 0;
    end
    r.failed   = bad;
    r.inverted = caret_seen;
    r.from_v   = f[VW-1:0];
    r.to_v     = t[VW-1:0];
    r.done     = fin;
    wipe_entry();
    return r;
  endfunction

  // Advance the parse by one character; returns 1 when an entry closes
  function automatic bit scan_char(input logic [7:0] c, input bit fin,
                                   output range_res_t r);
    bit     is_digit;
    bit     sign_ok;
    longint toff;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    r = '0;
    for (int pass = 0; pass < 3; pass++) begin
      sign_ok = !num_any && (c == CH_MINUS || c == CH_PLUS);
      case (scan_phase)
        SCAN_ENTRY: begin
          scan_phase = SCAN_FPRE;
          if (c == CH_CARET) begin
            caret_seen = 1'b1;
            if (fin) begin
              entry_bad = 1'b1;
              r = finish_entry(KIND_ABS, 0, fin);
              return 1'b1;
            end
            return 1'b0;
          end
        end
        SCAN_FPRE: begin
          scan_phase = SCAN_FNUM;
          if (c == CH_DOLLAR || c == CH_TILDE) begin
            from_kind = (c == CH_DOLLAR) ? KIND_UPPER : KIND_LOWER;
            if (fin) begin
              r = finish_entry(from_kind, 0, fin);
              return 1'b1;
            end
            return 1'b0;
          end
        end
        SCAN_FNUM: begin
          if (sign_ok || is_digit) begin
            if (is_digit) push_digit(int'(c - CH_ZERO));
            else num_neg = (c == CH_MINUS);
            num_any = 1'b1;
            if (fin) begin
              close_from();
              r = finish_entry(from_kind, from_off, fin);
              return 1'b1;
            end
            return 1'b0;
          end
          close_from();
          if (c == CH_COMMA) begin
            if (!from_given) entry_bad = 1'b1;
            r = finish_entry(from_kind, from_off, fin);
            return 1'b1;
          end
          if (c == CH_COLON) begin
            scan_phase = SCAN_TPRE;
            if (fin) begin
              toff = close_to();
              r = finish_entry(to_kind, toff, fin);
              return 1'b1;
            end
            return 1'b0;
          end
          entry_bad  = 1'b1;
          scan_phase = SCAN_SKIP;
          if (fin) begin
            r = finish_entry(KIND_ABS, 0, fin);
            return 1'b1;
          end
          return 1'b0;
        end
        SCAN_TPRE: begin
          scan_phase = SCAN_TNUM;
          if (c == CH_DOLLAR || c == CH_TILDE) begin
            to_kind = (c == CH_DOLLAR) ? KIND_UPPER : KIND_LOWER;
            if (fin) begin
              r = finish_entry(to_kind, 0, fin);
              return 1'b1;
            end
            return 1'b0;
          end
        end
        SCAN_TNUM: begin
          if (sign_ok || is_digit) begin
            if (is_digit) push_digit(int'(c - CH_ZERO));
            else num_neg = (c == CH_MINUS);
            num_any = 1'b1;
            if (fin) begin
              toff = close_to();
              r = finish_entry(to_kind, toff, fin);
              return 1'b1;
            end
            return 1'b0;
          end
          toff = close_to();
          if (c == CH_COMMA) begin
            r = finish_entry(to_kind, toff, fin);
            return 1'b1;
          end
          entry_bad  = 1'b1;
          scan_phase = SCAN_SKIP;
          if (fin) begin
            r = finish_entry(KIND_ABS, 0, fin);
            return 1'b1;
          end
          return 1'b0;
        end
        default: begin
          // skip up to the next separator
          entry_bad  = 1'b1;
          scan_phase = SCAN_SKIP;
          if (c == CH_COMMA || fin) begin
            r = finish_entry(KIND_ABS, 0, fin);
            return 1'b1;
          end
          return 1'b0;
        end
      endcase
    end
    return 1'b0;
  endfunction

  // Append one bound: optional prefix, then a number of some flavour
  function automatic void put_bound();
    int     roll;
    longint v;
    string  s;
    s    = "";
    roll = $urandom_range(0, 3);
    if (roll == 1) line_buf.push_back(CH_DOLLAR);
    else if (roll == 2) line_buf.push_back(CH_TILDE);
    roll = $urandom_range(0, 19);
    if (roll < 11) begin
      if ($urandom_range(0, 5) == 0) line_buf.push_back(CH_MINUS);
      else if ($urandom_range(0, 9) == 0) line_buf.push_back(CH_PLUS);
      s = $sformatf("%0d", $urandom_range(0, 1200));
    end else if (roll < 14) begin
      // land on or just beside one of the bounds
      v = $urandom_range(0, 1) ? longint'($signed(lower_q)) : longint'($signed(upper_q));
      v = v + longint'($urandom_range(0, 4)) - 2;
      s = $sformatf("%0d", v);
    end else if (roll < 16) begin
      if ($urandom_range(0, 1) == 0) line_buf.push_back(CH_MINUS);
      s = $sformatf("%0d", $urandom());
    end else if (roll < 18) begin
      repeat ($urandom_range(10, 12)) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end else if (roll == 18) begin
      line_buf.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
    end
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  // Append one entry, mostly well formed, sometimes noise or a stray byte
  function automatic void put_entry(bit with_comma);
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) line_buf.push_back(CH_CARET);
      if ($urandom_range(0, 9) < 8) put_bound();
      if ($urandom_range(0, 1) == 0) begin
        line_buf.push_back(CH_COLON);
        if ($urandom_range(0, 9) != 0) put_bound();
      end
      if ($urandom_range(0, 7) == 0) line_buf.push_back(8'($urandom_range(0, 255)));
    end
    if (with_comma) line_buf.push_back(CH_COMMA);
  endfunction

  function automatic void build_line();
    int n;
    bit trailing;
    line_buf.delete();
    n        = $urandom_range(1, 5);
    trailing = ($urandom_range(0, 5) == 0);
    for (int i = 0; i < n; i++) put_entry(i < n - 1 || trailing);
    if (line_buf.size() == 0) line_buf.push_back(CH_COMMA);
  endfunction

  // Offer one character beat; queue what it closes once it is taken
  task automatic send_char(input logic [7:0] c, input bit fin, input bit use_typed,
                           input range_res_t typed);
    range_res_t r;
    bit         got;
    int         gap;
    gap = 0;
    if (!sender_quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    got = scan_char(c, fin, r);
    if (got) expected_ranges.push_back(use_typed ? typed : r);
  endtask

  task automatic send_line();
    sink_quiet <= ($urandom_range(0, 3) == 0);
    for (int i = 0; i < line_buf.size(); i++)
      send_char(line_buf[i], i == line_buf.size() - 1, 1'b0, '0);
  endtask

  // Stop offering and let every outstanding result arrive
  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (expected_ranges.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_bounds(input logic [VW-1:0] lo, input logic [VW-1:0] hi);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LOWER_BOUND;
    cfg_data  <= lo;
    @(posedge clk_i);
    lower_q    = lo;
    cfg_index <= REG_UPPER_BOUND;
    cfg_data  <= hi;
    @(posedge clk_i);
    upper_q = hi;
    cfg_we <= 1'b0;
  endtask

  // Result sink: random stall bursts, one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken    <= 1'b1;
      hold_left     <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && !sink_quiet && $urandom_range(0, 4) == 0) begin
      stall_left    <= $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_ranges.size() == 0) begin
        $error("result beat with nothing expected: from %0d to %0d",
               $signed(m_axis_tdata[VW-1:0]), $signed(m_axis_tdata[2*VW-1:VW]));
        mismatches++;
      end else begin
        oldest_range = expected_ranges.pop_front();
        if (m_axis_tuser[0] !== oldest_range.failed) begin
          $error("failed: expected %0d, got %0d", oldest_range.failed, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tuser[1] !== oldest_range.inverted) begin
          $error("inverted: expected %0d, got %0d", oldest_range.inverted, m_axis_tuser[1]);
          mismatches++;
        end
        if (m_axis_tdata[VW-1:0] !== oldest_range.from_v) begin
          $error("from_value: expected %0d, got %0d", $signed(oldest_range.from_v),
                 $signed(m_axis_tdata[VW-1:0]));
          mismatches++;
        end
        if (m_axis_tdata[2*VW-1:VW] !== oldest_range.to_v) begin
          $error("to_value: expected %0d, got %0d", $signed(oldest_range.to_v),
                 $signed(m_axis_tdata[2*VW-1:VW]));
          mismatches++;
        end
        if (m_axis_tlast !== oldest_range.done) begin
          $error("string_done: expected %0d, got %0d", oldest_range.done, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: give up when no beat moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("range_list_text_parser_unit verification failed");
        $finish;
      end
    end
  end

  // Directed entries, parsed under the reset bounds
  probe_t probes [0:N_PROBES-1] = '{
    '{"5",            1'b1, 1'b1, 1'b0, 1'b0, 5, 5},
    '{"^",            1'b1, 1'b1, 1'b1, 1'b1, 0, 0},
    '{",",            1'b0, 1'b1, 1'b1, 1'b0, 0, 0},
    '{"3:7,",         1'b0, 1'b0, 1'b0, 1'b0, 0, 0},
    '{":,",           1'b0, 1'b1, 1'b1, 1'b0, 0, 0},
    '{"4:,",          1'b0, 1'b0, 1'b0, 1'b0, 0, 0},
    '{":9,",          1'b0, 1'b0, 1'b0, 1'b0, 0, 0},
    '{"^$:~,",        1'b0, 1'b0, 1'b0, 1'b0, 0, 0},
    '{"$5:~5,",       1'b0, 1'b0, 1'b0, 1'b0, 0, 0},
    '{"-1,",          1'b0, 1'b1, 1'b1, 1'b0, 0, 0},
    '{"+,",           1'b0, 1'b0, 1'b0, 1'b0, 0, 0},
    '{"2147483647,",  1'b0, 1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
    '{"2147483648,",  1'b0, 1'b1, 1'b1, 1'b0, 0, 0},
    '{"99999999999,", 1'b0, 1'b1, 1'b1, 1'b0, 0, 0},
    '{"1x2,",         1'b0, 1'b0, 1'b0, 1'b0, 0, 0},
    '{"1:2:3,",       1'b0, 1'b0, 1'b0, 1'b0, 0, 0},
    '{"--1,",         1'b0, 1'b0, 1'b0, 1'b0, 0, 0},
    '{"\377:,",       1'b0, 1'b0, 1'b0, 1'b0, 0, 0},
    '{"-2147483648,", 1'b0, 1'b0, 1'b0, 1'b0, 0, 0},
    '{"7,",           1'b1, 1'b0, 1'b0, 1'b0, 0, 0},
    '{"^$0:-0",       1'b1, 1'b0, 1'b0, 1'b0, 0, 0},
    '{"$",            1'b1, 1'b0, 1'b0, 1'b0, 0, 0},
    '{"~7:",          1'b1, 1'b0, 1'b0, 1'b0, 0, 0},
    '{":",            1'b1, 1'b1, 1'b1, 1'b0, 0, 0},
    '{"~:$",          1'b1, 1'b0, 1'b0, 1'b0, 0, 0}
  };

  // Bound settings of the random phases; the last one runs without idling
  int phase_lo [0:N_PHASES-1] = '{-1000, 32'sh8000_0000, 100, 32'sh8000_0000,
                                  32'sh7FFF_FFFF, 0};
  int phase_hi [0:N_PHASES-1] = '{1000, 32'sh7FFF_FFFF, 50, -5,
                                  32'sh7FFF_FFFF, 5000};

  initial begin
    range_res_t typed;
    int         sent;
    int         len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    for (int n = 0; n < N_PROBES; n++) begin
      sender_quiet   = ($urandom_range(0, 1) == 0);
      len            = probes[n].text.len();
      typed.failed   = probes[n].failed;
      typed.inverted = probes[n].inverted;
      typed.from_v   = probes[n].from_v;
      typed.to_v     = probes[n].to_v;
      typed.done     = probes[n].fin;
      for (int i = 0; i < len; i++)
        send_char(probes[n].text[i], probes[n].fin && i == len - 1,
                  probes[n].typed && i == len - 1, typed);
    end
    drain_pipe();

    // Random lines under each bound setting
    for (int p = 0; p < N_PHASES; p++) begin
      write_bounds(phase_lo[p], phase_hi[p]);
      calm <= (p == N_PHASES - 1);
      if (p == 1) hold_req <= 1'b1;
      sent = 0;
      while (sent < 45) begin
        build_line();
        sender_quiet = (p == 1) || (p == N_PHASES - 1) || ($urandom_range(0, 3) == 0);
        send_line();
        sent += line_buf.size();
      end
      drain_pipe();
    end

    if (mismatches == 0 && expected_ranges.size() == 0)
      $display("range_list_text_parser_unit verification clean");
    else
      $display("range_list_text_parser_unit verification failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rltp_pkg.sv
rtl/rltp_scan.sv
rtl/rltp_resolve.sv
rtl/range_list_text_parser_unit.sv
bench/tb_range_list_text_parser_unit.sv
